FILE: hw/rtl/fixed_point_decimal_formatter_top_assert.svh
// Assertion macros used by the decimal formatter engine.
`ifndef FIXED_POINT_DECIMAL_FORMATTER_TOP_ASSERT_SVH
`define FIXED_POINT_DECIMAL_FORMATTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FPDF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FPDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/fpdf_pkg.sv
// Types, constants and the power-of-ten table for the decimal formatter.
`default_nettype none

package fpdf_pkg;

   localparam int VALUE_W    = 33;
   localparam int UNIT_W     = 32;
   localparam int WORK_W     = 36;
   localparam int POW_W      = 34;
   localparam int POW10_W    = 30;
   localparam int CNT_W      = 6;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 8;
   localparam int DIV_STEPS  = VALUE_W;
   localparam int INT_DIGITS = 10;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SPACE,
      ST_MINUS,
      ST_INT,
      ST_POINT,
      ST_FMUL,
      ST_FSUB
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] character;
      logic              last;
   } emit_type;

   function automatic logic [POW10_W-1:0] pow10(input logic [DIGIT_W-1:0] k);
      logic [POW10_W-1:0] p;
      case (k)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = 30'd999999999;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fpdf_engine.sv
// Sequencer and shared subtractor that divide, split digits and produce characters.
`default_nettype none

`include "fixed_point_decimal_formatter_top_assert.svh"

module fpdf_engine (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [fpdf_pkg::VALUE_W-1:0]    value,
   input  logic        [fpdf_pkg::UNIT_W-1:0]     scale_unit,
   input  logic                                   leading_space,
   input  logic                                   out_free,
   output logic                                   busy,
   output fpdf_pkg::emit_type                     emit
);
   import fpdf_pkg::*;

   state_type            state_ff, state_in;
   logic [VALUE_W-1:0]   num_ff, num_in;
   logic [WORK_W-1:0]    rem_ff, rem_in;
   logic [UNIT_W-1:0]    unit_ff, unit_in;
   logic [POW_W-1:0]     pow_ff, pow_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIGIT_W-1:0]   dig_ff, dig_in;
   logic                 started_ff, started_in;
   logic                 space_ff, space_in;
   logic                 neg_ff, neg_in;

   logic [WORK_W-1:0]    sub_a, sub_b;
   logic [WORK_W:0]      sub_diff;
   logic                 borrow;
   logic                 fire;
   logic [POW_W+4:0]     pow20;
   logic [UNIT_W:0]      shifted;

   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow   = sub_diff[WORK_W];
   assign fire     = emit.valid && out_free;
   assign shifted  = {rem_ff[UNIT_W-1:0], num_ff[VALUE_W-1]};
   assign pow20    = {1'b0, pow_ff, 4'b0000} + {3'b000, pow_ff, 2'b00};

   // Outputs: operand selection for the subtractor and the character request.
   always_comb begin
      busy  = (state_ff != ST_IDLE);
      sub_a = '0;
      sub_b = {{(WORK_W-UNIT_W){1'b0}}, unit_ff};
      emit  = '0;
      case (state_ff)
         ST_DIV: begin
            sub_a = {{(WORK_W-UNIT_W-1){1'b0}}, shifted};
         end
         ST_SPACE: begin
            emit.valid     = 1'b1;
            emit.character = CH_SPACE;
         end
         ST_MINUS: begin
            emit.valid     = 1'b1;
            emit.character = CH_MINUS;
         end
         ST_INT: begin
            sub_a = {{(WORK_W-VALUE_W){1'b0}}, num_ff};
            sub_b = {{(WORK_W-POW10_W){1'b0}}, pow10(cnt_ff[DIGIT_W-1:0])};
            emit.valid     = borrow && (dig_ff != '0 || started_ff || cnt_ff == '0);
            emit.character = CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, dig_ff};
            emit.last      = (cnt_ff == '0) && (rem_ff == '0);
         end
         ST_POINT: begin
            emit.valid     = 1'b1;
            emit.character = CH_POINT;
         end
         ST_FSUB: begin
            sub_a = rem_ff;
            emit.valid     = borrow;
            emit.character = CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, dig_ff};
            // stop once nothing is left or the unit has run out of decades
            emit.last      = (rem_ff == '0) ||
                             ({{(POW_W+5-UNIT_W){1'b0}}, unit_ff} < pow20);
         end
         default: begin
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               if (space_ff)    state_in = ST_SPACE;
               else if (neg_ff) state_in = ST_MINUS;
               else             state_in = ST_INT;
            end
         end
         ST_SPACE: begin
            if (fire) state_in = neg_ff ? ST_MINUS : ST_INT;
         end
         ST_MINUS: begin
            if (fire) state_in = ST_INT;
         end
         ST_INT: begin
            if (fire && cnt_ff == '0) state_in = (rem_ff == '0) ? ST_IDLE : ST_POINT;
         end
         ST_POINT: begin
            if (fire) state_in = ST_FMUL;
         end
         ST_FMUL: begin
            state_in = ST_FSUB;
         end
         ST_FSUB: begin
            if (fire) state_in = emit.last ? ST_IDLE : ST_FMUL;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath.
   always_comb begin
      num_in     = num_ff;
      rem_in     = rem_ff;
      unit_in    = unit_ff;
      pow_in     = pow_ff;
      cnt_in     = cnt_ff;
      dig_in     = dig_ff;
      started_in = started_ff;
      space_in   = space_ff;
      neg_in     = neg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               num_in   = value[VALUE_W-1] ? (~value + 1'b1) : value;
               rem_in   = '0;
               unit_in  = (scale_unit == '0) ? {{(UNIT_W-1){1'b0}}, 1'b1} : scale_unit;
               pow_in   = {{(POW_W-1){1'b0}}, 1'b1};
               cnt_in   = CNT_W'(DIV_STEPS - 1);
               space_in = leading_space;
               neg_in   = value[VALUE_W-1];
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            num_in = {num_ff[VALUE_W-2:0], ~borrow};
            rem_in = borrow ? sub_a : sub_diff[WORK_W-1:0];
            if (cnt_ff == '0) begin
               cnt_in     = CNT_W'(INT_DIGITS - 1);
               dig_in     = '0;
               started_in = 1'b0;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_INT: begin
            if (!borrow) begin
               num_in = sub_diff[VALUE_W-1:0];
               dig_in = dig_ff + 1'b1;
            end else if (!emit.valid || fire) begin
               dig_in     = '0;
               cnt_in     = cnt_ff - 1'b1;
               started_in = started_ff | emit.valid;
            end
         end
         ST_FMUL: begin
            rem_in = {rem_ff[WORK_W-4:0], 3'b000} + {rem_ff[WORK_W-2:0], 1'b0};
            dig_in = '0;
         end
         ST_FSUB: begin
            if (!borrow) begin
               rem_in = sub_diff[WORK_W-1:0];
               dig_in = dig_ff + 1'b1;
            end else if (fire) begin
               pow_in = {pow_ff[POW_W-4:0], 3'b000} + {pow_ff[POW_W-2:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      unit_ff    <= unit_in;
      pow_ff     <= pow_in;
      cnt_ff     <= cnt_in;
      dig_ff     <= dig_in;
      started_ff <= started_in;
      space_ff   <= space_in;
      neg_ff     <= neg_in;
   end

   `FPDF_ASSERT_NEXT(a_last_ends_number, clock, reset, fire && emit.last, state_ff == ST_IDLE, "last character did not end the number")
   `FPDF_ASSERT_IMPLY(a_digit_range, clock, reset, emit.valid && (state_ff == ST_INT || state_ff == ST_FSUB), dig_ff <= 4'd9, "digit above nine")
   `FPDF_ASSERT_IMPLY(a_rem_below_unit, clock, reset, state_ff == ST_FMUL, rem_ff < {{(WORK_W-UNIT_W){1'b0}}, unit_ff}, "remainder not below unit")
   `FPDF_ASSERT_NEXT(a_start_divides, clock, reset, start && !busy, state_ff == ST_DIV, "accepted transaction did not start division")

endmodule

`default_nettype wire

FILE: hw/rtl/fixed_point_decimal_formatter_top.sv
// Top level of the fixed-point decimal formatter: handshakes and output register.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_value, req_scale_unit, req_leading_space
//   rsp     | out       | rsp_valid/rsp_stall | rsp_character, rsp_last (one per character)
//
// The sequencer divides by the unit on the shared subtractor, emits the optional space and
// minus, then finds each integer decade (leading zero decades included) and, after the point,
// each fraction digit by repeated subtraction on the same subtractor.
// req_stall stays high from acceptance until the last character is in the output register.
// Reset clears the sequencer and the output valid only.
// A stalled output register holds the sequencer at its next character.
`default_nettype none

module fixed_point_decimal_formatter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [fpdf_pkg::VALUE_W-1:0] req_value,
   input  logic        [fpdf_pkg::UNIT_W-1:0]  req_scale_unit,
   input  logic                                req_leading_space,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [fpdf_pkg::CHAR_W-1:0]  rsp_character,
   output logic                                rsp_last
);
   import fpdf_pkg::*;

   logic              busy;
   logic              out_free;
   emit_type          emit;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_character_ff, rsp_character_in;
   logic              rsp_last_ff, rsp_last_in;

   assign req_stall = busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   fpdf_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (req_valid && !busy),
      .value         (req_value),
      .scale_unit    (req_scale_unit),
      .leading_space (req_leading_space),
      .out_free      (out_free),
      .busy          (busy),
      .emit          (emit)
   );

   // Load a new character when the register frees up; drop valid once taken.
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      if (emit.valid && out_free) begin
         rsp_valid_in     = 1'b1;
         rsp_character_in = emit.character;
         rsp_last_in      = emit.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire
